[hdl/modexp_pseudo_mersenne_63_defines.svh]
// Assertion macros shared by the modular exponentiation block.
// Holds no logic; included by the modules that carry checks.
`ifndef MODEXP_PSEUDO_MERSENNE_63_DEFINES_SVH
`define MODEXP_PSEUDO_MERSENNE_63_DEFINES_SVH

`ifndef SYNTHESIS
`define MPM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("modexp check failed");
`define MPM_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("modexp forbidden condition seen");
`else
`define MPM_ASSERT(lbl, clk, rst, prop)
`define MPM_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

[hdl/mpm_pkg.sv]
// Shared types and constants for the modular exponentiation block.
// No dependencies; imported by the controller, datapath and top level.
package mpm_pkg;

  localparam int EXPONENT_BITS_DEF = 64;
  localparam int HALF_W = 32;

  // Modulus 2^63 - 25, and the fold constant 2^63 mod p.
  localparam logic [62:0] MOD_P = 63'h7FFF_FFFF_FFFF_FFE7;
  localparam logic [4:0]  FOLD  = 5'd25;

  // Partial product codes: which halves of a and b are multiplied.
  localparam logic [1:0] PP_LL = 2'd0;
  localparam logic [1:0] PP_HL = 2'd1;
  localparam logic [1:0] PP_LH = 2'd2;
  localparam logic [1:0] PP_HH = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BIT,
    ST_MUL,
    ST_SQR
  } mpm_state_t;

  typedef struct packed {
    logic       load;
    logic       pp_en;
    logic [1:0] pp_idx;
    logic       use_sq;
    logic       acc_en;
    logic [1:0] acc_idx;
    logic       red1;
    logic       red2;
    logic       wb;
    logic       shift_e;
  } mm_cmd_t;

  typedef struct packed {
    logic ebit;
  } mm_status_t;

endpackage

[hdl/mpm_datapath.sv]
// Datapath of the modular exponentiation block: operand registers, one shared
// 32x32 multiplier, a 128-bit product accumulator and the reduction modulo p.
// Depends on mpm_pkg and the assertion macro header.
`include "modexp_pseudo_mersenne_63_defines.svh"

module mpm_datapath #(
  parameter int EXPONENT_BITS = mpm_pkg::EXPONENT_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  mpm_pkg::mm_cmd_t   cmd,
  input  logic [63:0]        base,
  input  logic [63:0]        exponent,
  output mpm_pkg::mm_status_t status,
  output logic [62:0]        result
);
  import mpm_pkg::*;

  localparam logic [63:0] TWO_P = {MOD_P, 1'b0};

  logic [63:0]              sq;
  logic [62:0]              acc;
  logic [EXPONENT_BITS-1:0] ereg;
  logic [63:0]              p;
  logic [127:0]             accum;
  logic [70:0]              t;
  logic [63:0]              r;

  logic [63:0]  op_a;
  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [127:0] pp_shifted;
  logic [63:0]  wb_val;

  always_comb begin
    op_a   = cmd.use_sq ? sq : {1'b0, acc};
    a_half = cmd.pp_idx[0] ? op_a[63:32] : op_a[31:0];
    b_half = cmd.pp_idx[1] ? sq[63:32] : sq[31:0];
    case (cmd.acc_idx)
      PP_LL:   pp_shifted = {64'd0, p};
      PP_HL:   pp_shifted = {32'd0, p, 32'd0};
      PP_LH:   pp_shifted = {32'd0, p, 32'd0};
      PP_HH:   pp_shifted = {p, 64'd0};
      default: pp_shifted = {64'd0, p};
    endcase
    // r stays below 2p, so one conditional subtract finishes the reduction.
    if (r >= {1'b0, MOD_P}) begin
      wb_val = r - {1'b0, MOD_P};
    end else begin
      wb_val = r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq   <= base;
      acc  <= 63'd1;
      ereg <= exponent[EXPONENT_BITS-1:0];
    end else begin
      if (cmd.shift_e) begin
        ereg <= ereg >> 1;
      end
      if (cmd.wb) begin
        if (cmd.use_sq) begin
          sq <= {1'b0, wb_val[62:0]};
        end else begin
          acc <= wb_val[62:0];
        end
      end
    end
    if (cmd.pp_en) begin
      p <= {32'd0, a_half} * {32'd0, b_half};
    end
    if (cmd.acc_en) begin
      if (cmd.acc_idx == PP_LL) begin
        accum <= pp_shifted;
      end else begin
        accum <= accum + pp_shifted;
      end
    end
    // Fold the bits above 2^63 back in with 2^63 = 25 (mod p), twice.
    if (cmd.red1) begin
      t <= {6'd0, accum[127:63]} * 71'(FOLD) + {8'd0, accum[62:0]};
    end
    if (cmd.red2) begin
      r <= {56'd0, t[70:63]} * 64'(FOLD) + {1'b0, t[62:0]};
    end
  end

  assign status.ebit = ereg[0];
  assign result      = acc;

  `MPM_ASSERT(a_red_bound, clk, rst, cmd.wb |-> r < TWO_P)
  `MPM_ASSERT(a_acc_reduced, clk, rst, (cmd.wb && !cmd.use_sq) |=> acc < MOD_P)
  `MPM_ASSERT(a_red_order, clk, rst, cmd.red1 |-> $past(cmd.acc_en && cmd.acc_idx == PP_HH))

endmodule

[hdl/mpm_ctrl.sv]
// Controller of the modular exponentiation block: walks the exponent bits and
// sequences each modular product through the datapath, one step per cycle.
// Depends on mpm_pkg and the assertion macro header.
`include "modexp_pseudo_mersenne_63_defines.svh"

module mpm_ctrl #(
  parameter int EXPONENT_BITS = mpm_pkg::EXPONENT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mpm_pkg::mm_status_t status,
  output mpm_pkg::mm_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import mpm_pkg::*;

  localparam int CNT_W = (EXPONENT_BITS > 1) ? $clog2(EXPONENT_BITS) : 1;
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(EXPONENT_BITS - 1);

  mpm_state_t       state;
  mpm_state_t       state_next;
  logic [2:0]       step;
  logic [2:0]       step_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             done_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= 3'd0;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      cnt   <= cnt_next;
      done  <= done_next;
    end
  end

  always_comb begin
    state_next  = state;
    step_next   = step;
    cnt_next    = cnt;
    done_next   = 1'b0;
    cmd         = '0;
    cmd.use_sq  = (state == ST_SQR);
    cmd.pp_idx  = step[1:0];
    cmd.acc_idx = 2'(step - 3'd1);
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          cnt_next   = '0;
          state_next = ST_BIT;
        end
      end
      ST_BIT: begin
        step_next  = 3'd0;
        state_next = status.ebit ? ST_MUL : ST_SQR;
      end
      ST_MUL, ST_SQR: begin
        // Four partial products, then accumulate, fold twice and write back.
        cmd.pp_en  = (step <= 3'd3);
        cmd.acc_en = (step >= 3'd1) && (step <= 3'd4);
        cmd.red1   = (step == 3'd5);
        cmd.red2   = (step == 3'd6);
        cmd.wb     = (step == 3'd7);
        step_next  = step + 3'd1;
        if (step == 3'd7) begin
          if (state == ST_MUL) begin
            state_next = ST_SQR;
          end else begin
            cmd.shift_e = 1'b1;
            if (cnt == LAST_BIT) begin
              state_next = ST_IDLE;
              done_next  = 1'b1;
            end else begin
              cnt_next   = cnt + CNT_W'(1);
              state_next = ST_BIT;
            end
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign busy = (state != ST_IDLE);

  `MPM_ASSERT(a_done_after_sqr, clk, rst, done |-> $past(cmd.wb && cmd.use_sq))
  `MPM_ASSERT_NEVER(a_done_busy, clk, rst, done && busy)
  `MPM_ASSERT(a_start_bit, clk, rst, (start && !busy) |=> (state == ST_BIT && cnt == '0))

endmodule

[hdl/modexp_pseudo_mersenne_63.sv]
// Top level of the modular exponentiation block modulo p = 2^63 - 25.
// Depends on mpm_pkg, mpm_ctrl and mpm_datapath.

// An item (base, exponent) is taken when start is high while busy is low, and
// base^exponent mod p is on result while done is high for exactly one cycle;
// the receiver cannot stall, so it must take the result in that cycle. The
// exponent's low EXPONENT_BITS bits are scanned from the least significant
// end; each bit passes a decision state, then the multiply when the bit is
// set, then the squaring. busy is already low in the done cycle, so a new
// item may be started there. Each product uses the single 32x32 multiplier
// four times, followed by two folding steps and a final conditional subtract.
module modexp_pseudo_mersenne_63 #(
  parameter int EXPONENT_BITS = mpm_pkg::EXPONENT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] base,
  input  logic [63:0] exponent,
  output logic        done,
  output logic [62:0] result
);
  import mpm_pkg::*;

  mm_cmd_t    cmd;
  mm_status_t status;

  mpm_ctrl #(
    .EXPONENT_BITS(EXPONENT_BITS)
  ) u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  mpm_datapath #(
    .EXPONENT_BITS(EXPONENT_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .base     (base),
    .exponent (exponent),
    .status   (status),
    .result   (result)
  );

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for modexp_pseudo_mersenne_63 (base^exponent mod 2^63 - 25).
// Depends on mpm_pkg and the block's RTL. A directed table runs first, then random items
// are predicted with a 128-bit square-and-multiply model.
module tb;

  localparam int          EXP_BITS     = mpm_pkg::EXPONENT_BITS_DEF;
  localparam logic [63:0] PRIME        = 64'(mpm_pkg::MOD_P);
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          N_DIRECTED   = 22;
  localparam int          N_RANDOM     = 880;
  localparam int          MAX_REPORTS  = 10;
  localparam int          DRAIN_CYCLES = 1200;
  // Watchdog on the whole run, set well above the time that all items and gaps take.
  localparam longint      LIMIT_CYCLES = 6_000_000;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] exponent;
    logic        typed;
    logic [62:0] power;
  } stim_row_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] exponent;
    logic [62:0] power;
  } pending_power_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] base;
  logic [63:0] exponent;
  logic        done;
  logic [62:0] result;

  stim_row_t      directed_rows [N_DIRECTED];
  pending_power_t pending_powers [$];
  pending_power_t oldest;
  int             error_count;
  longint         cycle_count;

  modexp_pseudo_mersenne_63 #(
    .EXPONENT_BITS(EXP_BITS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .base(base),
    .exponent(exponent),
    .done(done),
    .result(result)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [63:0] mul_mod_prime(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod % {64'd0, PRIME});
  endfunction

  // Square-and-multiply from the least significant exponent bit upward.
  function automatic logic [62:0] pow_mod_prime(input logic [63:0] b, input logic [63:0] e);
    logic [63:0] sq;
    logic [63:0] acc;
    sq  = b;
    acc = 64'd1;
    for (int k = 0; k < EXP_BITS; k++) begin
      if (e[k]) acc = mul_mod_prime(acc, sq);
      sq = mul_mod_prime(sq, sq);
    end
    return acc[62:0];
  endfunction

  task automatic note_error(input string what, input logic [63:0] b, input logic [63:0] e,
                            input logic [62:0] want, input logic [62:0] got);
    if (error_count < MAX_REPORTS) begin
      $display("%0t: %s base=%h exponent=%h expected=%h actual=%h",
               $realtime, what, b, e, want, got);
    end
    error_count++;
  endtask

  // Drives one item from the current falling edge and holds it until the transfer.
  // A zero gap leaves start high so the next item follows on the next falling edge.
  task automatic send_item(input logic [63:0] b, input logic [63:0] e,
                           input logic [62:0] want, input int gap);
    start    <= 1'b1;
    base     <= b;
    exponent <= e;
    do @(posedge clk); while (busy);
    pending_powers.push_back('{base: b, exponent: e, power: want});
    @(negedge clk);
    if (gap > 0) begin
      start    <= 1'b0;
      base     <= {$urandom(), $urandom()};
      exponent <= {$urandom(), $urandom()};
      repeat (gap) @(negedge clk);
    end
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_powers.size() == 0) begin
        note_error("result with no item outstanding", 64'd0, 64'd0, 63'd0, result);
      end else begin
        oldest = pending_powers.pop_front();
        if (result !== oldest.power) begin
          note_error("wrong result", oldest.base, oldest.exponent, oldest.power, result);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    logic [63:0] b;
    logic [63:0] e;
    logic [62:0] want;
    int          gap;

    rst         = 1'b1;
    start       = 1'b0;
    base        = 64'd0;
    exponent    = 64'd0;
    error_count = 0;
    cycle_count = 0;

    directed_rows = '{
      '{64'd0,                  64'd0,                  1'b1, 63'd1},
      '{PRIME,                  64'd0,                  1'b1, 63'd1},
      '{ALL_ONES,               64'd0,                  1'b1, 63'd1},
      '{64'd0,                  64'd1,                  1'b1, 63'd0},
      '{64'd0,                  ALL_ONES,               1'b1, 63'd0},
      '{64'd1,                  ALL_ONES,               1'b1, 63'd1},
      '{PRIME,                  64'd5,                  1'b1, 63'd0},
      '{64'hFFFF_FFFF_FFFF_FFCE, 64'd7,                 1'b1, 63'd0},
      '{PRIME + 64'd1,          ALL_ONES,               1'b1, 63'd1},
      '{64'd2,                  64'd1,                  1'b1, 63'd2},
      '{ALL_ONES,               64'd1,                  1'b1, 63'd49},
      '{PRIME - 64'd1,          64'd1,                  1'b1, 63'h7FFF_FFFF_FFFF_FFE6},
      '{PRIME - 64'd1,          64'd2,                  1'b1, 63'd1},
      '{PRIME - 64'd1,          ALL_ONES,               1'b1, 63'h7FFF_FFFF_FFFF_FFE6},
      '{64'd2,                  64'd63,                 1'b1, 63'd25},
      '{64'd2,                  64'd64,                 1'b1, 63'd50},
      '{64'h8000_0000_0000_0000, 64'd1,                 1'b1, 63'd25},
      '{ALL_ONES,               ALL_ONES,               1'b0, 63'd0},
      '{64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 1'b0, 63'd0},
      '{64'h0000_0000_FFFF_FFFF, 64'h5555_5555_5555_5555, 1'b0, 63'd0},
      '{64'hDEAD_BEEF_0123_4567, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 63'd0},
      '{64'hFFFF_FFFF_0000_0000, 64'h8000_0000_0000_0001, 1'b0, 63'd0}
    };

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED + N_RANDOM; i++) begin
      if (i < N_DIRECTED) begin
        b    = directed_rows[i].base;
        e    = directed_rows[i].exponent;
        want = directed_rows[i].typed ? directed_rows[i].power : pow_mod_prime(b, e);
      end else begin
        b = {$urandom(), $urandom()};
        e = {$urandom(), $urandom()};
        case ($urandom_range(0, 9))
          0: b = 64'($urandom_range(0, 3));
          1: b = PRIME + 64'($urandom_range(0, 8)) - 64'd4;
          2: b = ALL_ONES - 64'($urandom_range(0, 60));
          3: e = 64'($urandom_range(0, 70));
          4: e = e & {$urandom(), $urandom()} & {$urandom(), $urandom()};
          5: e = ALL_ONES ^ (64'd1 << $urandom_range(0, 63));
          default: ;
        endcase
        want = pow_mod_prime(b, e);
      end
      gap = (i == N_DIRECTED + N_RANDOM - 1) ? 1 : pick_gap();
      send_item(b, e, want, gap);
    end

    while (pending_powers.size() != 0) @(posedge clk);
    // Any spurious late result would show up within one more item time.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mpm_pkg.sv
hdl/mpm_datapath.sv
hdl/mpm_ctrl.sv
hdl/modexp_pseudo_mersenne_63.sv
tb/sv/tb.sv
